// File: rtl/tsakf_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and saturation helpers for the two-state angle Kalman filter.
// No dependencies; used by two_state_angle_kalman_filter.
package tsakf_pkg;

  // Default number of fractional bits of the fixed-point format
  localparam int FRAC_BITS_DEF = 16;

  // Field widths
  localparam int DATA_W = 32;
  localparam int DT_W   = 24;
  localparam int CFG_W  = 31;

  typedef logic signed [DATA_W-1:0] fix_t;

  // Configuration register index, taken from paddr[2]
  typedef enum logic {
    REG_PROCESS_NOISE = 1'b0,
    REG_MEAS_NOISE    = 1'b1
  } reg_idx_e;

  localparam fix_t FIX_MAX = 32'sh7fff_ffff;
  localparam fix_t FIX_MIN = 32'sh8000_0000;

  // Clamp a 33-bit signed sum to 32 bits
  function automatic fix_t sat33(input logic signed [32:0] v);
    fix_t r;
    if (v > 33'sh0_7fff_ffff) begin
      r = FIX_MAX;
    end else if (v < -33'sh0_8000_0000) begin
      r = FIX_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Clamp a 64-bit signed value to 32 bits
  function automatic fix_t sat64(input logic signed [63:0] v);
    fix_t r;
    if (v > 64'sh0000_0000_7fff_ffff) begin
      r = FIX_MAX;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = FIX_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/two_state_angle_kalman_filter.sv
`timescale 1ns / 1ps
// Two-state (angle, rate) Kalman filter built around one shared multiplier and one
// shift-subtract divider under a small sequencer. Depends on tsakf_pkg.
//
// Channel   | Direction | Handshake                | Payload
// ----------+-----------+--------------------------+--------------------------------------
// s_axis    | in        | s_axis_tvalid/tready     | tdata: angle_meas, rate_meas, elapsed
// m_axis    | out       | m_axis_tvalid/tready     | tdata: angle_est, rate_est
// apb       | in        | psel/penable/pwrite      | process_noise @0x0, meas_noise @0x4
//
// An accepted item keeps the input closed until the sequencer is back to idle; the result
// is loaded in the cycle before that. The time is set mostly by the two quotient divisions
// that retire one bit per cycle over 32 + FRAC_BITS bits; nine multiply-accumulate ops
// run on the shared multiplier, each through S_MUL and S_ACC. A zero innovation
// variance skips both bit loops.
// rst_ni clears the estimates, loads the covariance diagonal and meas_noise with 0.1.
// The result waits in an output register; the next item is taken while it waits, and
// the sequencer only holds if a new result is ready before the previous one is taken.
module two_state_angle_kalman_filter #(
  parameter int FRAC_BITS = tsakf_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] angle_meas, [63:32] rate_meas, [87:64] elapsed_time
  input  logic [87:0] s_axis_tdata,
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] angle_est, [63:32] rate_est
  output logic [63:0] m_axis_tdata,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DW        = 32 + FRAC_BITS;          // dividend / quotient bits
  localparam int CW        = $clog2(DW + 1);
  localparam int ONE_TENTH = ((1 << FRAC_BITS) + 5) / 10;
  localparam logic [DW-1:0] Q_POS_LIM = DW'(64'h7fff_ffff);
  localparam logic [DW-1:0] Q_NEG_LIM = DW'(64'h8000_0000);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_ADDQ,
    S_PREP,
    S_DIV_INIT,
    S_DIV_RUN,
    S_DIV_DONE,
    S_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_ANGLE_PRED,
    OP_CROSS_PRED,
    OP_PA_OLD,
    OP_PA_NEW,
    OP_ANGLE_UPD,
    OP_RATE_UPD,
    OP_PA_UPD,
    OP_PR_UPD,
    OP_CROSS_UPD
  } op_e;

  // control and filter state
  state_e                         state_q;
  op_e                            op_q;
  logic                           first_q;
  logic                           div_sel_q;
  logic [CW-1:0]                  cnt_q;
  logic                           m_valid_q;
  logic [tsakf_pkg::CFG_W-1:0]    q_q;
  logic [tsakf_pkg::CFG_W-1:0]    r_q;
  tsakf_pkg::fix_t                ang_q;
  tsakf_pkg::fix_t                rate_q;
  tsakf_pkg::fix_t                pa_q;
  tsakf_pkg::fix_t                pc_q;
  tsakf_pkg::fix_t                pr_q;
  tsakf_pkg::fix_t                cn_q;

  // payload and datapath registers
  tsakf_pkg::fix_t                z_q;
  logic [tsakf_pkg::DT_W-1:0]     dt_q;
  logic signed [63:0]             prod_q;
  logic signed [33:0]             s_q;
  tsakf_pkg::fix_t                y_q;
  tsakf_pkg::fix_t                k0_q;
  tsakf_pkg::fix_t                k1_q;
  logic [DW-1:0]                  dvd_q;
  logic [32:0]                    dvs_q;
  logic [32:0]                    rem_q;
  logic                           neg_q;
  tsakf_pkg::fix_t                out_ang_q;
  tsakf_pkg::fix_t                out_rate_q;

  // combinational datapath
  tsakf_pkg::fix_t                mul_a;
  tsakf_pkg::fix_t                mul_b;
  tsakf_pkg::fix_t                addend;
  logic                           op_sub;
  logic signed [63:0]             prod_d;
  logic signed [63:0]             prod_sh;
  tsakf_pkg::fix_t                msat;
  logic signed [32:0]             sum33;
  tsakf_pkg::fix_t                acc_res;
  tsakf_pkg::fix_t                dt_fix;
  tsakf_pkg::fix_t                num;
  logic [31:0]                    num_mag;
  logic [32:0]                    s_mag;
  logic [33:0]                    trial;
  logic                           q_bit;
  tsakf_pkg::fix_t                gain_d;
  logic                           in_acc;
  logic                           out_free;
  logic                           cfg_wr;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {out_rate_q, out_ang_q};
  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite && pready;
  assign dt_fix        = $signed({8'd0, dt_q});

  // Register readback
  always_comb begin
    if (paddr[2] == tsakf_pkg::REG_MEAS_NOISE) begin
      prdata = {1'b0, r_q};
    end else begin
      prdata = {1'b0, q_q};
    end
  end

  // Operand, addend and sign select for each multiply-accumulate op
  always_comb begin
    unique case (op_q)
      OP_ANGLE_PRED: begin mul_a = dt_fix; mul_b = rate_q; addend = ang_q;  op_sub = 1'b0; end
      OP_CROSS_PRED: begin mul_a = dt_fix; mul_b = pr_q;   addend = pc_q;   op_sub = 1'b0; end
      OP_PA_OLD:     begin mul_a = dt_fix; mul_b = pc_q;   addend = pa_q;   op_sub = 1'b0; end
      OP_PA_NEW:     begin mul_a = dt_fix; mul_b = cn_q;   addend = pa_q;   op_sub = 1'b0; end
      OP_ANGLE_UPD:  begin mul_a = k0_q;   mul_b = y_q;    addend = ang_q;  op_sub = 1'b0; end
      OP_RATE_UPD:   begin mul_a = k1_q;   mul_b = y_q;    addend = rate_q; op_sub = 1'b0; end
      OP_PA_UPD:     begin mul_a = k0_q;   mul_b = pa_q;   addend = pa_q;   op_sub = 1'b1; end
      OP_PR_UPD:     begin mul_a = k1_q;   mul_b = pc_q;   addend = pr_q;   op_sub = 1'b1; end
      OP_CROSS_UPD:  begin mul_a = k0_q;   mul_b = pc_q;   addend = pc_q;   op_sub = 1'b1; end
      default:       begin mul_a = '0;     mul_b = '0;     addend = '0;     op_sub = 1'b0; end
    endcase
  end

  // Shared multiplier, then floor scaling, clamp and accumulate
  always_comb begin
    prod_d  = mul_a * mul_b;
    prod_sh = prod_q >>> FRAC_BITS;
    msat    = tsakf_pkg::sat64(prod_sh);
    if (op_sub) begin
      sum33 = {addend[31], addend} - {msat[31], msat};
    end else begin
      sum33 = {addend[31], addend} + {msat[31], msat};
    end
    acc_res = tsakf_pkg::sat33(sum33);
  end

  // Divider operands, one restoring step, and quotient clamp
  always_comb begin
    num     = div_sel_q ? pc_q : pa_q;
    num_mag = num[31] ? 32'(-num) : 32'(num);
    s_mag   = s_q[33] ? 33'(-s_q) : 33'(s_q);
    trial   = {rem_q, dvd_q[DW-1]};
    q_bit   = (trial >= {1'b0, dvs_q});
    if (!neg_q) begin
      gain_d = (dvd_q > Q_POS_LIM) ? tsakf_pkg::FIX_MAX : dvd_q[31:0];
    end else begin
      gain_d = (dvd_q > Q_NEG_LIM) ? tsakf_pkg::FIX_MIN : 32'(-dvd_q);
    end
  end

  // Sequencer, filter state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= OP_ANGLE_PRED;
      first_q   <= 1'b1;
      div_sel_q <= 1'b0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
      q_q       <= '0;
      r_q       <= tsakf_pkg::CFG_W'(ONE_TENTH);
      ang_q     <= '0;
      rate_q    <= '0;
      pa_q      <= 32'(ONE_TENTH);
      pc_q      <= '0;
      pr_q      <= 32'(ONE_TENTH);
      cn_q      <= '0;
    end else begin
      // configuration writes
      if (cfg_wr) begin
        if (paddr[2] == tsakf_pkg::REG_MEAS_NOISE) begin
          r_q <= pwdata[tsakf_pkg::CFG_W-1:0];
        end else begin
          q_q <= pwdata[tsakf_pkg::CFG_W-1:0];
        end
      end

      // drop the result once taken, unless a new one is loaded
      if (state_q == S_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            rate_q  <= $signed(s_axis_tdata[63:32]);
            first_q <= 1'b0;
            op_q    <= OP_ANGLE_PRED;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          state_q <= S_ACC;
        end
        S_ACC: begin
          unique case (op_q)
            OP_ANGLE_PRED: begin ang_q <= acc_res; op_q <= OP_CROSS_PRED; state_q <= S_MUL; end
            OP_CROSS_PRED: begin cn_q  <= acc_res; op_q <= OP_PA_OLD;     state_q <= S_MUL; end
            OP_PA_OLD:     begin pa_q  <= acc_res; op_q <= OP_PA_NEW;     state_q <= S_MUL; end
            OP_PA_NEW:     begin pa_q  <= acc_res;                        state_q <= S_ADDQ; end
            OP_ANGLE_UPD:  begin ang_q <= acc_res; op_q <= OP_RATE_UPD;   state_q <= S_MUL; end
            OP_RATE_UPD:   begin rate_q <= acc_res; op_q <= OP_PA_UPD;    state_q <= S_MUL; end
            OP_PA_UPD:     begin pa_q  <= acc_res; op_q <= OP_PR_UPD;     state_q <= S_MUL; end
            OP_PR_UPD:     begin pr_q  <= acc_res; op_q <= OP_CROSS_UPD;  state_q <= S_MUL; end
            OP_CROSS_UPD:  begin pc_q  <= acc_res;                        state_q <= S_DONE; end
            default:       begin                                          state_q <= S_IDLE; end
          endcase
        end
        S_ADDQ: begin
          // add process noise to both diagonal terms, commit the new cross term
          pa_q    <= tsakf_pkg::sat33($signed({pa_q[31], pa_q} + {2'b00, q_q}));
          pr_q    <= tsakf_pkg::sat33($signed({pr_q[31], pr_q} + {2'b00, q_q}));
          pc_q    <= cn_q;
          state_q <= S_PREP;
        end
        S_PREP: begin
          div_sel_q <= 1'b0;
          state_q   <= S_DIV_INIT;
        end
        S_DIV_INIT: begin
          cnt_q <= CW'(DW);
          if (s_q == '0) begin
            state_q <= S_DIV_DONE;
          end else begin
            state_q <= S_DIV_RUN;
          end
        end
        S_DIV_RUN: begin
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            state_q <= S_DIV_DONE;
          end
        end
        S_DIV_DONE: begin
          if (!div_sel_q) begin
            div_sel_q <= 1'b1;
            state_q   <= S_DIV_INIT;
          end else begin
            op_q    <= OP_ANGLE_UPD;
            state_q <= S_MUL;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath and payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      z_q  <= $signed(s_axis_tdata[31:0]);
      dt_q <= first_q ? '0 : s_axis_tdata[87:64];
    end

    if (state_q == S_MUL) begin
      prod_q <= prod_d;
    end

    // innovation variance and residual
    if (state_q == S_PREP) begin
      s_q <= {{2{pa_q[31]}}, pa_q} + {3'b000, r_q};
      y_q <= tsakf_pkg::sat33({z_q[31], z_q} - {ang_q[31], ang_q});
    end

    // load magnitudes; a zero variance yields a zero gain
    if (state_q == S_DIV_INIT) begin
      rem_q <= '0;
      dvs_q <= s_mag;
      if (s_q == '0) begin
        dvd_q <= '0;
        neg_q <= 1'b0;
      end else begin
        dvd_q <= {num_mag, {FRAC_BITS{1'b0}}};
        neg_q <= num[31] ^ s_q[33];
      end
    end

    // shift one quotient bit into the dividend register
    if (state_q == S_DIV_RUN) begin
      rem_q <= q_bit ? 33'(trial - {1'b0, dvs_q}) : trial[32:0];
      dvd_q <= {dvd_q[DW-2:0], q_bit};
    end

    if (state_q == S_DIV_DONE) begin
      if (div_sel_q) begin
        k1_q <= gain_d;
      end else begin
        k0_q <= gain_d;
      end
    end

    if (state_q == S_DONE && out_free) begin
      out_ang_q  <= ang_q;
      out_rate_q <= rate_q;
    end
  end

  // An accepted item closes the input until the sequencer is back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again right after an accept");

  // The bit counter never runs past the quotient width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DW))
    else $error("divider counter out of range");

  // A new result appears only out of the final sequencer state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_DONE))
    else $error("result valid without a finished item");

  // The divider runs only while the innovation variance is nonzero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV_RUN |-> s_q != '0)
    else $error("division started on a zero variance");

endmodule
